[hdl/plcr_pkg.sv]
// shared types, constants and register codes for the piecewise linear colour ramp
// no dependencies; every other file of the block imports this package
`default_nettype none

package plcr_pkg;

    // field widths
    localparam int POS_W      = 16;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int COLOUR_W   = NUM_CH * CH_W;
    localparam int NUM_STOPS  = 4;
    localparam int STOP_IDX_W = 2;
    localparam int MAX_STOPS  = 4;
    localparam int STOP_CNT_W = 3;
    localparam int ANCHOR_W   = NUM_STOPS * POS_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHORS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_3   = 3'd5;

    // divider: quotient bits and remainder width (2*255*65535 + 65535 fits in 25 bits)
    localparam int QUO_W = CH_W;
    localparam int REM_W = 2 * POS_W - QUO_W + 1;

    // relief preset loaded at reset
    localparam logic [STOP_CNT_W-1:0] STOP_COUNT_RESET = 3'd4;
    localparam logic [ANCHOR_W-1:0]   ANCHORS_RESET    = 64'hFFFF_A000_6000_0000;
    localparam logic [COLOUR_W-1:0]   COLOUR_0_RESET   = 24'hA0DC69;
    localparam logic [COLOUR_W-1:0]   COLOUR_1_RESET   = 24'hFFE673;
    localparam logic [COLOUR_W-1:0]   COLOUR_2_RESET   = 24'hA89B8A;
    localparam logic [COLOUR_W-1:0]   COLOUR_3_RESET   = 24'hF2F2F2;
    localparam logic [COLOUR_W-1:0]   COLOUR_WHITE     = 24'hFFFFFF;

    typedef logic [NUM_STOPS-1:0][POS_W-1:0]    anchor_set_t;
    typedef logic [NUM_STOPS-1:0][COLOUR_W-1:0] colour_set_t;

    // segment choice for one item
    typedef struct packed {
        logic                bypass;
        logic [COLOUR_W-1:0] colour;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    lo;
        logic [POS_W-1:0]    hi;
        logic [COLOUR_W-1:0] ca;
        logic [COLOUR_W-1:0] cb;
    } sel_t;

    // fraction and per-channel spans
    typedef struct packed {
        logic                          bypass;
        logic [COLOUR_W-1:0]           colour;
        logic [POS_W-1:0]              num;
        logic [POS_W-1:0]              den;
        logic [NUM_CH-1:0][CH_W-1:0]   lower;
        logic [NUM_CH-1:0][CH_W-1:0]   diff;
        logic [NUM_CH-1:0]             down;
    } prep_t;

    // one channel in the divider
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [CH_W-1:0]  lower;
        logic             down;
    } lane_t;

    // item in the divider pipeline
    typedef struct packed {
        logic                bypass;
        logic [COLOUR_W-1:0] colour;
        logic [REM_W-1:0]    dsh;
        lane_t [NUM_CH-1:0]  lane;
    } div_t;

endpackage

`default_nettype wire

[hdl/piecewise_linear_colour_ramp.sv]
// top level of the piecewise linear colour ramp: stream in, stream out, config port
// depends on plcr_pkg, plcr_cfg_regs, plcr_seg_select, plcr_div_stage
//
// usage
//   s_tdata carries a 16-bit position (65535 is 1.0); m_tdata returns the colour.
//   the cfg channel writes one register per handshake: 0 stop count, 1 packed
//   anchors, 2..5 stop colours; cfg_ready is always high, higher indexes are
//   dropped. write configuration only while the pipeline is empty.
// timing
//   twelve register stages: segment select, span prep, multiply, eight restoring
//   divider steps (one quotient bit each, three channels in parallel) and the
//   output register, in that order.
//   throughput is one item per cycle while m_tready stays high.
// reset
//   aresetn low loads the relief preset (four stops) and empties the pipeline.
// stall
//   with m_tready low each full stage holds its item and empty stages keep
//   filling, so s_tready drops only once all twelve stages hold an item.
`default_nettype none

module piecewise_linear_colour_ramp
    import plcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [POS_W-1:0]      s_tdata,   // [15:0] position
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [COLOUR_W-1:0]        m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [STOP_CNT_W-1:0] stop_count;
    anchor_set_t           anchors;
    colour_set_t           colours;

    assign cfg_ready = 1'b1;

    plcr_cfg_regs u_cfg_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cfg_valid & cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .stop_count (stop_count),
        .anchors    (anchors),
        .colours    (colours)
    );

    // stage enables: a stage moves when empty or when the next one moves
    logic s1_en, s2_en, s3_en, out_en;
    logic div_en   [QUO_W];
    logic div_valid[QUO_W+1];
    div_t div_data [QUO_W+1];

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    sel_t  sel_comb, s1_reg;
    prep_t s2_reg, s2_next;
    div_t  s3_reg, s3_next;
    logic                m_tvalid_reg;
    logic [COLOUR_W-1:0] m_tdata_reg, m_tdata_next;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign s3_en    = !s3_valid_reg || div_en[0];
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;

    // stage 1: segment select
    plcr_seg_select u_seg_select (
        .x          (s_tdata),
        .stop_count (stop_count),
        .anchors    (anchors),
        .colours    (colours),
        .sel        (sel_comb)
    );

    // stage 2: fraction, segment length and channel spans
    always_comb begin
        logic [CH_W-1:0] ca_c;
        logic [CH_W-1:0] cb_c;
        s2_next.bypass = s1_reg.bypass;
        s2_next.colour = s1_reg.colour;
        s2_next.num    = s1_reg.x - s1_reg.lo;
        s2_next.den    = s1_reg.hi - s1_reg.lo;
        for (int c = 0; c < NUM_CH; c++) begin
            ca_c = s1_reg.ca[(NUM_CH - 1 - c) * CH_W +: CH_W];
            cb_c = s1_reg.cb[(NUM_CH - 1 - c) * CH_W +: CH_W];
            s2_next.lower[c] = ca_c;
            s2_next.down[c]  = cb_c < ca_c;
            s2_next.diff[c]  = (cb_c < ca_c) ? (ca_c - cb_c) : (cb_c - ca_c);
        end
    end

    // stage 3: span times fraction, biased by half the divisor for rounding
    always_comb begin
        logic [POS_W+CH_W-1:0] prod;
        s3_next.bypass = s2_reg.bypass;
        s3_next.colour = s2_reg.colour;
        s3_next.dsh    = REM_W'(s2_reg.den) << QUO_W;
        for (int c = 0; c < NUM_CH; c++) begin
            prod = (POS_W + CH_W)'(s2_reg.diff[c]) * (POS_W + CH_W)'(s2_reg.num);
            s3_next.lane[c].rem   = {prod, 1'b0} + REM_W'(s2_reg.den);
            s3_next.lane[c].quo   = '0;
            s3_next.lane[c].lower = s2_reg.lower[c];
            s3_next.lane[c].down  = s2_reg.down[c];
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_en) s1_valid_reg <= s_tvalid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload of the front stages
    always_ff @(posedge aclk) begin
        if (s1_en) s1_reg <= sel_comb;
        if (s2_en) s2_reg <= s2_next;
        if (s3_en) s3_reg <= s3_next;
    end

    // divider chain, one quotient bit per stage
    assign div_valid[0] = s3_valid_reg;
    assign div_data[0]  = s3_reg;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        if (k == QUO_W - 1) begin : g_last
            assign div_en[k] = !div_valid[k+1] || out_en;
        end else begin : g_mid
            assign div_en[k] = !div_valid[k+1] || div_en[k+1];
        end

        plcr_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_en  (div_en[k]),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // output stage: apply the rounded step toward the upper colour
    always_comb begin
        div_t            fin;
        logic [CH_W-1:0] q;
        fin = div_data[QUO_W];
        for (int c = 0; c < NUM_CH; c++) begin
            q = fin.lane[c].quo;
            if (fin.bypass) begin
                m_tdata_next[c * CH_W +: CH_W] = fin.colour[(NUM_CH - 1 - c) * CH_W +: CH_W];
            end else if (fin.lane[c].down) begin
                m_tdata_next[c * CH_W +: CH_W] = fin.lane[c].lower - q;
            end else begin
                m_tdata_next[c * CH_W +: CH_W] = fin.lane[c].lower + q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= div_valid[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // input is refused only when every stage is full and the receiver stalls
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg &&
                       div_valid[QUO_W] && m_tvalid_reg && !m_tready))
        else $error("input refused while the pipeline has room");

    // a ready receiver never backs up into the input
    a_ready_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("ready chain broken");

    // a blended item always has a fraction strictly inside its segment
    a_fraction_in_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !s2_reg.bypass) |->
            (s2_reg.num != '0 && s2_reg.num < s2_reg.den))
        else $error("blend fraction outside its segment");

endmodule

`default_nettype wire

[hdl/plcr_cfg_regs.sv]
// configuration registers of the colour ramp: stop count, anchors, stop colours
// depends on plcr_pkg
`default_nettype none

module plcr_cfg_regs
    import plcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output logic [STOP_CNT_W-1:0]      stop_count,
    output anchor_set_t                anchors,
    output colour_set_t                colours
);

    logic [STOP_CNT_W-1:0] stop_count_reg, stop_count_next;
    anchor_set_t           anchors_reg, anchors_next;
    colour_set_t           colours_reg, colours_next;

    // register write decode, unknown indexes ignored
    always_comb begin
        stop_count_next = stop_count_reg;
        anchors_next    = anchors_reg;
        colours_next    = colours_reg;
        if (wr_en) begin
            unique case (wr_index) inside
                REG_STOP_COUNT: stop_count_next = wr_data[STOP_CNT_W-1:0];
                REG_ANCHORS:    anchors_next    = wr_data[ANCHOR_W-1:0];
                REG_COLOUR_0, REG_COLOUR_1, REG_COLOUR_2, REG_COLOUR_3: begin
                    colours_next[STOP_IDX_W'(wr_index - REG_COLOUR_0)] =
                        wr_data[COLOUR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // relief preset at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RESET;
            anchors_reg    <= ANCHORS_RESET;
            colours_reg    <= {COLOUR_3_RESET, COLOUR_2_RESET, COLOUR_1_RESET, COLOUR_0_RESET};
        end else begin
            stop_count_reg <= stop_count_next;
            anchors_reg    <= anchors_next;
            colours_reg    <= colours_next;
        end
    end

    assign stop_count = stop_count_reg;
    assign anchors    = anchors_reg;
    assign colours    = colours_reg;

endmodule

`default_nettype wire

[hdl/plcr_seg_select.sv]
// segment search of the colour ramp: picks a fixed colour or the segment to blend
// depends on plcr_pkg
`default_nettype none

module plcr_seg_select
    import plcr_pkg::*;
(
    input  wire logic [POS_W-1:0]      x,
    input  wire logic [STOP_CNT_W-1:0] stop_count,
    input  wire anchor_set_t           anchors,
    input  wire colour_set_t           colours,
    output sel_t                       sel
);

    logic [STOP_CNT_W-1:0] n;
    logic [STOP_IDX_W-1:0] idx_last;
    logic [STOP_IDX_W-1:0] seg;
    logic [STOP_IDX_W-1:0] seg_hi;
    logic [NUM_STOPS-1:0]  lt;
    logic [NUM_STOPS-1:0]  le;
    logic                  found;

    // compare the position against every anchor at once
    always_comb begin
        for (int j = 0; j < NUM_STOPS; j++) begin
            lt[j] = x <  anchors[j];
            le[j] = x <= anchors[j];
        end
    end

    // saturated stop count and first segment whose upper anchor is above x
    always_comb begin
        n        = (stop_count > STOP_CNT_W'(MAX_STOPS)) ? STOP_CNT_W'(MAX_STOPS) : stop_count;
        idx_last = STOP_IDX_W'(n - 1'b1);
        found    = 1'b0;
        seg      = '0;
        for (int i = 0; i < NUM_STOPS - 1; i++) begin
            if (!found && (STOP_CNT_W'(i + 1) < n) && lt[i + 1]) begin
                found = 1'b1;
                seg   = STOP_IDX_W'(i);
            end
        end
        seg_hi = seg + 1'b1;
    end

    // fixed colour for the edge cases, otherwise the segment ends
    always_comb begin
        sel.x      = x;
        sel.lo     = anchors[seg];
        sel.hi     = anchors[seg_hi];
        sel.ca     = colours[seg];
        sel.cb     = colours[seg_hi];
        sel.bypass = 1'b1;
        sel.colour = COLOUR_WHITE;
        if (n == '0) begin
            sel.colour = COLOUR_WHITE;
        end else if (n == STOP_CNT_W'(1) || le[0]) begin
            sel.colour = colours[0];
        end else if (!lt[idx_last]) begin
            sel.colour = colours[idx_last];
        end else if (found) begin
            // x on the lower anchor or out-of-order anchors: take the lower colour
            if (le[seg]) begin
                sel.colour = colours[seg];
            end else begin
                sel.bypass = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/plcr_div_stage.sv]
// one restoring step of the rounding divider, three channels side by side, registered
// depends on plcr_pkg
`default_nettype none

module plcr_div_stage
    import plcr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic stage_en,
    input  wire logic in_valid,
    input  wire div_t in_data,
    output logic      out_valid,
    output div_t      out_data
);

    logic valid_reg;
    div_t data_reg, data_next;

    // subtract the shifted divisor where it fits, shift in one quotient bit
    always_comb begin
        logic [REM_W:0] trial;
        logic           take;
        data_next     = in_data;
        data_next.dsh = in_data.dsh >> 1;
        for (int c = 0; c < NUM_CH; c++) begin
            trial = {1'b0, in_data.lane[c].rem} - {1'b0, in_data.dsh};
            take  = !trial[REM_W];
            data_next.lane[c].rem = take ? trial[REM_W-1:0] : in_data.lane[c].rem;
            data_next.lane[c].quo = {in_data.lane[c].quo[QUO_W-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
